[design/dss_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package dss_pkg;

    localparam int DEPTH_DEF  = 16;
    localparam int ADDR_MAX_W = 6;
    localparam int LEN_MAX_W  = 7;
    localparam int DATA_W     = 32;
    localparam int MODE_W     = 3;
    localparam int STAT_W     = 2;
    localparam int QDEPTH     = 4;
    localparam int Q_AW       = 2;

    localparam logic [MODE_W-1:0] MODE_PUSH_A = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_B = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_A  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_B  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DUMP_A = 3'd4;
    localparam logic [MODE_W-1:0] MODE_DUMP_B = 3'd5;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 2'd2;
    localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd3;

    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_STATUS = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    typedef struct packed {
        logic [1:0]            kind;
        logic [ADDR_MAX_W-1:0] addr;
        logic [LEN_MAX_W-1:0]  len;
        logic                  down;
        logic [DATA_W-1:0]     value;
        logic [STAT_W-1:0]     status;
    } t_cmd;

endpackage

`default_nettype wire

[design/dual_stack_shared_memory.sv]
`timescale 1ns / 1ps
`default_nettype none
// Two stacks in one shared RAM of DEPTH words: stack A grows up from entry 0,
// stack B grows down from the top entry.
// Input channel (s_axis): tuser carries the mode (push A, push B, pop A,
// pop B, dump A, dump B), tdata the value to push. Unused modes are dropped.
// Output channel (m_axis): tdata is the popped or dumped word, tuser the
// status (ok, overflow, underflow, empty dump), tlast marks the final beat
// caused by one input beat. A dump gives one beat per element, an empty
// stack one empty-status beat.
// The front end classifies each beat and updates the stack counts in the
// accept cycle, then hands a command to a four-entry queue. The back end
// executes commands in order against the RAM.
// A push or error result goes to the output register as the back end takes
// it, a pop via the registered RAM read port. One push or error retires per
// cycle while the receiver is ready; one RAM read is in flight at a time.
// Input is accepted while the queue has room. When the receiver stalls,
// the output register holds its beat and the back end waits; the queue
// keeps taking input until it fills.
// Reset empties both stacks and the queue; RAM contents are not cleared.

module dual_stack_shared_memory
    import dss_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  wire logic [DATA_W-1:0] i_s_axis_tdata,  // [31:0] push_value
    input  wire logic [MODE_W-1:0] i_s_axis_tuser,  // [2:0] mode
    output logic                   o_m_axis_tvalid,
    input  wire logic              i_m_axis_tready,
    output logic      [DATA_W-1:0] o_m_axis_tdata,  // [31:0] data_out
    output logic      [STAT_W-1:0] o_m_axis_tuser,  // [1:0] status
    output logic                   o_m_axis_tlast
);

    localparam int AW = $clog2(DEPTH);

    t_cmd              front_cmd;
    logic              front_push;
    logic              q_ready;
    logic              q_valid;
    t_cmd              q_cmd;
    logic              q_pop;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    dss_front #(
        .DEPTH(DEPTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_mode   (i_s_axis_tuser),
        .i_value  (i_s_axis_tdata),
        .o_push   (front_push),
        .o_cmd    (front_cmd),
        .i_q_ready(q_ready)
    );

    dss_cmd_q u_cmd_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (front_push),
        .i_cmd  (front_cmd),
        .o_ready(q_ready),
        .o_valid(q_valid),
        .o_cmd  (q_cmd),
        .i_pop  (q_pop)
    );

    dss_back #(
        .DEPTH(DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(q_valid),
        .i_cmd      (q_cmd),
        .o_cmd_pop  (q_pop),
        .o_we       (ram_we),
        .o_waddr    (ram_waddr),
        .o_wdata    (ram_wdata),
        .o_re       (ram_re),
        .o_raddr    (ram_raddr),
        .i_rdata    (ram_rdata),
        .o_valid    (o_m_axis_tvalid),
        .o_data     (o_m_axis_tdata),
        .o_status   (o_m_axis_tuser),
        .o_last     (o_m_axis_tlast),
        .i_ready    (i_m_axis_tready)
    );

    dss_ram #(
        .WIDTH(DATA_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

endmodule

`default_nettype wire

[design/dss_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module dss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[design/dss_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module dss_front
    import dss_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [MODE_W-1:0] i_mode,
    input  wire logic [DATA_W-1:0] i_value,
    output logic                   o_push,
    output t_cmd                   o_cmd,
    input  wire logic              i_q_ready
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    logic [CW-1:0] r_cnt_a, n_cnt_a;
    logic [CW-1:0] r_cnt_b, n_cnt_b;
    logic          accept;
    logic          known;
    logic          full;
    logic [CW-1:0] a_top;
    logic [CW-1:0] b_next;
    logic [CW-1:0] b_top;

    assign o_ready = i_q_ready;
    assign accept  = i_valid && i_q_ready;
    assign full    = ({1'b0, r_cnt_a} + {1'b0, r_cnt_b}) >= {1'b0, DEPTH_C};
    assign a_top   = r_cnt_a - CW'(1);
    assign b_top   = DEPTH_C - r_cnt_b;
    assign b_next  = b_top - CW'(1);

    always_comb begin
        n_cnt_a      = r_cnt_a;
        n_cnt_b      = r_cnt_b;
        known        = 1'b1;
        o_cmd.kind   = CMD_STATUS;
        o_cmd.addr   = '0;
        o_cmd.len    = LEN_MAX_W'(1);
        o_cmd.down   = 1'b0;
        o_cmd.value  = i_value;
        o_cmd.status = STAT_OK;
        case (i_mode)
            MODE_PUSH_A: begin
                if (full) begin
                    o_cmd.status = STAT_OVERFLOW;
                end else begin
                    o_cmd.kind = CMD_WRITE;
                    o_cmd.addr = ADDR_MAX_W'(r_cnt_a[AW-1:0]);
                    n_cnt_a    = r_cnt_a + CW'(1);
                end
            end
            MODE_PUSH_B: begin
                if (full) begin
                    o_cmd.status = STAT_OVERFLOW;
                end else begin
                    o_cmd.kind = CMD_WRITE;
                    o_cmd.addr = ADDR_MAX_W'(b_next[AW-1:0]);
                    n_cnt_b    = r_cnt_b + CW'(1);
                end
            end
            MODE_POP_A: begin
                if (r_cnt_a == '0) begin
                    o_cmd.status = STAT_UNDERFLOW;
                end else begin
                    o_cmd.kind = CMD_READ;
                    o_cmd.addr = ADDR_MAX_W'(a_top[AW-1:0]);
                    n_cnt_a    = a_top;
                end
            end
            MODE_POP_B: begin
                if (r_cnt_b == '0) begin
                    o_cmd.status = STAT_UNDERFLOW;
                end else begin
                    o_cmd.kind = CMD_READ;
                    o_cmd.addr = ADDR_MAX_W'(b_top[AW-1:0]);
                    n_cnt_b    = r_cnt_b - CW'(1);
                end
            end
            MODE_DUMP_A: begin
                if (r_cnt_a == '0) begin
                    o_cmd.status = STAT_EMPTY;
                end else begin
                    o_cmd.kind = CMD_READ;
                    o_cmd.addr = ADDR_MAX_W'(a_top[AW-1:0]);
                    o_cmd.len  = LEN_MAX_W'(r_cnt_a);
                    o_cmd.down = 1'b1;
                end
            end
            MODE_DUMP_B: begin
                if (r_cnt_b == '0) begin
                    o_cmd.status = STAT_EMPTY;
                end else begin
                    o_cmd.kind = CMD_READ;
                    o_cmd.addr = ADDR_MAX_W'(b_top[AW-1:0]);
                    o_cmd.len  = LEN_MAX_W'(r_cnt_b);
                end
            end
            default: begin
                // drop unused modes
                known = 1'b0;
            end
        endcase
    end

    assign o_push = accept && known;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_a <= '0;
            r_cnt_b <= '0;
        end else if (accept) begin
            r_cnt_a <= n_cnt_a;
            r_cnt_b <= n_cnt_b;
        end
    end

endmodule

`default_nettype wire

[design/dss_cmd_q.sv]
`timescale 1ns / 1ps
`default_nettype none

module dss_cmd_q
    import dss_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_cmd      i_cmd,
    output logic      o_ready,
    output logic      o_valid,
    output t_cmd      o_cmd,
    input  wire logic i_pop
);

    t_cmd            r_slot [QDEPTH];
    logic [Q_AW-1:0] r_wptr;
    logic [Q_AW-1:0] r_rptr;
    logic [Q_AW:0]   r_cnt;
    logic            do_pop;

    assign o_ready = r_cnt != (Q_AW + 1)'(QDEPTH);
    assign o_valid = r_cnt != '0;
    assign o_cmd   = r_slot[r_rptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + Q_AW'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + Q_AW'(1);
            end
            if (i_push && !do_pop) begin
                r_cnt <= r_cnt + (Q_AW + 1)'(1);
            end else if (do_pop && !i_push) begin
                r_cnt <= r_cnt - (Q_AW + 1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

[design/dss_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module dss_back
    import dss_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cmd_valid,
    input  t_cmd                          i_cmd,
    output logic                          o_cmd_pop,
    output logic                          o_we,
    output logic [$clog2(DEPTH)-1:0]      o_waddr,
    output logic [DATA_W-1:0]             o_wdata,
    output logic                          o_re,
    output logic [$clog2(DEPTH)-1:0]      o_raddr,
    input  wire logic [DATA_W-1:0]        i_rdata,
    output logic                          o_valid,
    output logic [DATA_W-1:0]             o_data,
    output logic [STAT_W-1:0]             o_status,
    output logic                          o_last,
    input  wire logic                     i_ready
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic              r_busy;
    logic [AW-1:0]     r_addr;
    logic [CW-1:0]     r_left;
    logic              r_down;
    logic              r_pend;
    logic              r_pend_last;
    logic              r_ovalid;
    logic [DATA_W-1:0] r_odata;
    logic [STAT_W-1:0] r_ostat;
    logic              r_olast;

    logic              slot_free;
    logic              take_head;
    logic              walk_step;
    logic              head_read;
    logic [CW-1:0]     head_len;
    logic [AW-1:0]     head_addr;

    // issue only when the output register is empty by the time read data lands
    assign slot_free = !r_pend && (!r_ovalid || i_ready);
    assign take_head = !r_busy && i_cmd_valid && slot_free;
    assign walk_step = r_busy && slot_free;
    assign head_read = i_cmd.kind == CMD_READ;
    assign head_len  = i_cmd.len[CW-1:0];
    assign head_addr = i_cmd.addr[AW-1:0];

    assign o_cmd_pop = take_head;
    assign o_we      = take_head && (i_cmd.kind == CMD_WRITE);
    assign o_waddr   = head_addr;
    assign o_wdata   = i_cmd.value;
    assign o_re      = (take_head && head_read) || walk_step;
    assign o_raddr   = r_busy ? r_addr : head_addr;

    assign o_valid  = r_ovalid;
    assign o_data   = r_odata;
    assign o_status = r_ostat;
    assign o_last   = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_pend <= o_re;
            if (take_head && head_read) begin
                r_busy <= head_len != CW'(1);
            end else if (walk_step) begin
                r_busy <= r_left != CW'(1);
            end
            if (r_pend) begin
                r_ovalid <= 1'b1;
            end else if (take_head && !head_read) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_head && head_read) begin
            r_left      <= head_len - CW'(1);
            r_down      <= i_cmd.down;
            r_addr      <= i_cmd.down ? head_addr - AW'(1) : head_addr + AW'(1);
            r_pend_last <= head_len == CW'(1);
        end else if (walk_step) begin
            r_left      <= r_left - CW'(1);
            r_addr      <= r_down ? r_addr - AW'(1) : r_addr + AW'(1);
            r_pend_last <= r_left == CW'(1);
        end
        if (r_pend) begin
            r_odata <= i_rdata;
            r_ostat <= STAT_OK;
            r_olast <= r_pend_last;
        end else if (take_head && !head_read) begin
            r_odata <= '0;
            r_ostat <= i_cmd.status;
            r_olast <= 1'b1;
        end
    end

endmodule

`default_nettype wire
